>>> src/htm_pkg.sv
// Shared types, name ROM and helper functions of the HTTP token table matcher.
package htm_pkg;

    // Field widths fixed by the channel formats.
    localparam int TOKEN_BYTE_W = 8;
    localparam int ENTRY_IDX_W  = 6;
    localparam int NAME_LEN_W   = 5;
    localparam int KIND_W       = 2;
    localparam int POS_W        = 5;

    // Defaults of the top-level parameters.
    localparam int MAX_NAME_LEN_DEF = 25;
    localparam int MAX_ENTRIES_DEF  = 42;

    // Longest name held in the ROM, in bytes.
    localparam int ROM_NAME_MAX = 25;
    localparam int NAME_BITS    = 8 * ROM_NAME_MAX;

    // Sizes of the name groups.
    localparam int N_REQ = 21;
    localparam int N_RSP = 9;
    localparam int N_GEN = 11;
    localparam int N_ENT = 10;
    localparam int N_MTH = 8;
    localparam int N_VER = 2;

    localparam int REQ_IW = $clog2(N_REQ);
    localparam int RSP_IW = $clog2(N_RSP);
    localparam int GEN_IW = $clog2(N_GEN);
    localparam int ENT_IW = $clog2(N_ENT);
    localparam int MTH_IW = $clog2(N_MTH);
    localparam int VER_IW = $clog2(N_VER);

    typedef enum logic [KIND_W-1:0] {
        KIND_REQUEST  = 2'd0,
        KIND_RESPONSE = 2'd1,
        KIND_METHOD   = 2'd2,
        KIND_VERSION  = 2'd3
    } t_table_kind;

    typedef logic [NAME_BITS-1:0]  t_rom_name;
    typedef logic [NAME_LEN_W-1:0] t_name_len;

    typedef struct packed {
        t_rom_name name;
        t_name_len len;
    } t_rom_rec;

    // Payload of one input transfer.
    typedef struct packed {
        logic [TOKEN_BYTE_W-1:0] token_byte;
        logic                    last_byte;
        logic [KIND_W-1:0]       table_kind;
    } t_in_item;

    // Payload of one result transfer.
    typedef struct packed {
        logic                   found;
        logic [ENTRY_IDX_W-1:0] entry_index;
        logic [NAME_LEN_W-1:0]  name_length;
    } t_out_item;

    // Name strings are right-aligned: the first character sits in the
    // highest occupied byte.
    localparam t_rom_name REQ_NAMES [N_REQ] = '{
        "User-Agent", "TE", "Referer", "Range", "Proxy-Authorization",
        "Max-Forwards", "If-Unmodified-Since", "If-Range", "If-None-Match",
        "If-Modified-Since", "If-Match", "Host", "From", "Expect",
        "Authorization", "Accept-Language", "Accept-Encoding", "Accept-Charset",
        "Accept", "X-API-Key", "Proxy-Connection"
    };
    localparam t_name_len REQ_LENS [N_REQ] = '{
        5'd10, 5'd2, 5'd7, 5'd5, 5'd19, 5'd12, 5'd19, 5'd8, 5'd13, 5'd17,
        5'd8, 5'd4, 5'd4, 5'd6, 5'd13, 5'd15, 5'd15, 5'd14, 5'd6, 5'd9, 5'd16
    };

    localparam t_rom_name RSP_NAMES [N_RSP] = '{
        "WWW-Authenticate", "Vary", "Server", "Retry-After", "Proxy-Authenticate",
        "Location", "ETag", "Age", "Accept-Ranges"
    };
    localparam t_name_len RSP_LENS [N_RSP] = '{
        5'd16, 5'd4, 5'd6, 5'd11, 5'd18, 5'd8, 5'd4, 5'd3, 5'd13
    };

    localparam t_rom_name GEN_NAMES [N_GEN] = '{
        "Warning", "Via", "Upgrade", "Transfer-Encoding",
        "Content-Transfer-Encoding", "Trailer", "Pragma", "Date", "Connection",
        "Keep-Alive", "Cache-Control"
    };
    localparam t_name_len GEN_LENS [N_GEN] = '{
        5'd7, 5'd3, 5'd7, 5'd17, 5'd25, 5'd7, 5'd6, 5'd4, 5'd10, 5'd10, 5'd13
    };

    localparam t_rom_name ENT_NAMES [N_ENT] = '{
        "Last-Modified", "Expires", "Content-Type", "Content-Range", "Content-MD5",
        "Content-Location", "Content-Length", "Content-Language",
        "Content-Encoding", "Allow"
    };
    localparam t_name_len ENT_LENS [N_ENT] = '{
        5'd13, 5'd7, 5'd12, 5'd13, 5'd11, 5'd16, 5'd14, 5'd16, 5'd16, 5'd5
    };

    localparam t_rom_name MTH_NAMES [N_MTH] = '{
        "OPTIONS", "GET", "HEAD", "POST", "PUT", "DELETE", "TRACE", "CONNECT"
    };
    localparam t_name_len MTH_LENS [N_MTH] = '{
        5'd7, 5'd3, 5'd4, 5'd4, 5'd3, 5'd6, 5'd5, 5'd7
    };
    // Only GET, POST and CONNECT are supported methods.
    localparam logic MTH_OK [N_MTH] = '{
        1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1
    };

    localparam t_rom_name VER_NAMES [N_VER] = '{"HTTP/1.0", "HTTP/1.1"};
    localparam t_name_len VER_LENS [N_VER]  = '{5'd8, 5'd8};

    // Fold upper-case ASCII letters to lower case.
    function automatic logic [TOKEN_BYTE_W-1:0] fold(input logic [TOKEN_BYTE_W-1:0] c);
        return ((c >= "A") && (c <= "Z")) ? c + 8'd32 : c;
    endfunction

    // Name and length of an entry of a table kind; length zero marks no candidate.
    function automatic t_rom_rec rom_entry(input logic [KIND_W-1:0] kind,
                                           input logic [ENTRY_IDX_W-1:0] idx);
        t_rom_rec                 rec;
        logic [ENTRY_IDX_W-1:0]   head;
        logic [ENTRY_IDX_W-1:0]   rel;
        rec.name = '0;
        rec.len  = '0;
        head     = '0;
        rel      = '0;
        case (t_table_kind'(kind))
            KIND_REQUEST, KIND_RESPONSE: begin
                head = (t_table_kind'(kind) == KIND_REQUEST) ?
                       ENTRY_IDX_W'(N_REQ) : ENTRY_IDX_W'(N_RSP);
                if (idx < head) begin
                    if (t_table_kind'(kind) == KIND_REQUEST) begin
                        rec.name = REQ_NAMES[idx[REQ_IW-1:0]];
                        rec.len  = REQ_LENS[idx[REQ_IW-1:0]];
                    end else begin
                        rec.name = RSP_NAMES[idx[RSP_IW-1:0]];
                        rec.len  = RSP_LENS[idx[RSP_IW-1:0]];
                    end
                end else begin
                    rel = idx - head;
                    if (rel < ENTRY_IDX_W'(N_GEN)) begin
                        rec.name = GEN_NAMES[rel[GEN_IW-1:0]];
                        rec.len  = GEN_LENS[rel[GEN_IW-1:0]];
                    end else begin
                        rel = rel - ENTRY_IDX_W'(N_GEN);
                        if (rel < ENTRY_IDX_W'(N_ENT)) begin
                            rec.name = ENT_NAMES[rel[ENT_IW-1:0]];
                            rec.len  = ENT_LENS[rel[ENT_IW-1:0]];
                        end
                    end
                end
            end
            KIND_METHOD: begin
                if (idx < ENTRY_IDX_W'(N_MTH)) begin
                    if (MTH_OK[idx[MTH_IW-1:0]]) begin
                        rec.name = MTH_NAMES[idx[MTH_IW-1:0]];
                        rec.len  = MTH_LENS[idx[MTH_IW-1:0]];
                    end
                end
            end
            KIND_VERSION: begin
                if (idx < ENTRY_IDX_W'(N_VER)) begin
                    rec.name = VER_NAMES[idx[VER_IW-1:0]];
                    rec.len  = VER_LENS[idx[VER_IW-1:0]];
                end
            end
            default: ;
        endcase
        return rec;
    endfunction

    // Folded name character at a byte position; zero past the end of the name.
    function automatic logic [TOKEN_BYTE_W-1:0] rom_char(input logic [KIND_W-1:0] kind,
                                                         input logic [ENTRY_IDX_W-1:0] idx,
                                                         input logic [POS_W-1:0] pos);
        t_rom_rec                rec;
        logic [NAME_LEN_W-1:0]   sh;
        logic [TOKEN_BYTE_W-1:0] ch;
        rec = rom_entry(kind, idx);
        sh  = '0;
        ch  = '0;
        if (pos < rec.len) begin
            sh = rec.len - pos - NAME_LEN_W'(1);
            ch = rec.name[8*sh +: 8];
        end
        return fold(ch);
    endfunction

endpackage

>>> src/htm_chan_if.sv
// Valid/ready channel interface carrying one payload per transfer.
interface htm_chan_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> src/http_token_table_matcher_core.sv
// Top level of the HTTP token table matcher.
//
// Usage: a token is sent one byte per transfer on i_in_chan, first byte first,
// with last_byte set on its final byte. table_kind selects request headers,
// response headers, methods or versions and is sampled on the token's first
// byte only. Letters are compared without regard to case; an entry matches
// when its whole name is a prefix of the token.
// One result transfer leaves on o_res_chan for each last byte: found, the
// index of the first matching entry in table order and its name length, or
// zeros when nothing matched.
// Throughput: one byte per cycle, unless a last byte waits for the result path;
// every entry is compared in the same cycle. A last byte goes through the input
// register, the compare logic, the completion register and the result register.
// Reset: clears the byte position and latched kind and empties all stages;
// the first byte after reset starts a new token.
// Stall: while the result register waits, the compare stage and one held
// completion keep accepting bytes; only a further last byte waits in the input
// register, and input ready drops until the result is taken.
module http_token_table_matcher_core
    import htm_pkg::*;
#(
    parameter int MAX_NAME_LEN = MAX_NAME_LEN_DEF,
    parameter int MAX_ENTRIES  = MAX_ENTRIES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    htm_chan_if.sink   i_in_chan,
    htm_chan_if.source o_res_chan
);

    logic                   r_s1_valid;
    t_in_item               r_s1;
    logic                   s1_go;
    logic                   s1_free;
    logic                   fin_free;
    logic [MAX_ENTRIES-1:0] fin_vec;
    logic [KIND_W-1:0]      fin_kind;

    // A non-last byte always moves on; a last byte needs room for its completion.
    assign s1_go             = r_s1_valid && (!r_s1.last_byte || fin_free);
    assign s1_free           = !r_s1_valid || s1_go;
    assign i_in_chan.ready   = s1_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_free) begin
            r_s1_valid <= i_in_chan.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_free && i_in_chan.valid) begin
            r_s1 <= i_in_chan.payload;
        end
    end

    htm_match_stage #(
        .MAX_NAME_LEN (MAX_NAME_LEN),
        .MAX_ENTRIES  (MAX_ENTRIES)
    ) u_match (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step_en  (s1_go),
        .i_item     (r_s1),
        .o_fin_vec  (fin_vec),
        .o_fin_kind (fin_kind)
    );

    htm_result_stage #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_result (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fin_load (s1_go && r_s1.last_byte),
        .i_fin_vec  (fin_vec),
        .i_fin_kind (fin_kind),
        .o_fin_free (fin_free),
        .o_res_chan (o_res_chan)
    );

    // Input can only be held off by a last byte waiting for the result path.
    a_stall_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_chan.ready |-> (r_s1_valid && r_s1.last_byte))
        else $error("input stalled without a pending last byte");

    // A miss carries zero index and zero length.
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_chan.valid && !o_res_chan.payload.found) |->
        (o_res_chan.payload.entry_index == '0 && o_res_chan.payload.name_length == '0))
        else $error("miss result with nonzero fields");

    // A hit always names a non-empty entry.
    a_hit_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_chan.valid && o_res_chan.payload.found) |->
        (o_res_chan.payload.name_length != '0))
        else $error("hit result with zero name length");

    // A completion is only taken while the result path has room for it.
    a_load_from_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_go && r_s1.last_byte) |-> fin_free)
        else $error("completion loaded while result path full");

endmodule

>>> src/htm_match_stage.sv
// Per-entry compare logic and candidate state of the token matcher.
module htm_match_stage
    import htm_pkg::*;
#(
    parameter int MAX_NAME_LEN = MAX_NAME_LEN_DEF,
    parameter int MAX_ENTRIES  = MAX_ENTRIES_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_step_en,
    input  t_in_item               i_item,
    output logic [MAX_ENTRIES-1:0] o_fin_vec,
    output logic [KIND_W-1:0]      o_fin_kind
);

    logic [POS_W-1:0]       r_pos,   n_pos;
    logic [KIND_W-1:0]      r_kind,  n_kind;
    logic [MAX_ENTRIES-1:0] r_alive, n_alive;
    logic [MAX_ENTRIES-1:0] r_comp,  n_comp;

    // Compare the current byte against every live entry in parallel.
    always_comb begin
        logic                    start;
        logic                    in_range;
        logic [TOKEN_BYTE_W-1:0] fb;
        logic                    alive_cur;
        logic                    comp_cur;
        t_rom_rec                rec;
        logic [TOKEN_BYTE_W-1:0] ch;
        start    = (r_pos == '0);
        n_kind   = start ? i_item.table_kind : r_kind;
        in_range = (r_pos < POS_W'(MAX_NAME_LEN));
        fb       = fold(i_item.token_byte);
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            alive_cur  = start ? 1'b1 : r_alive[i];
            comp_cur   = start ? 1'b0 : r_comp[i];
            rec        = rom_entry(n_kind, ENTRY_IDX_W'(i));
            ch         = rom_char(n_kind, ENTRY_IDX_W'(i), r_pos);
            n_alive[i] = alive_cur;
            n_comp[i]  = comp_cur;
            if (in_range && alive_cur && !comp_cur) begin
                if ((rec.len == '0) || (rec.len > NAME_LEN_W'(MAX_NAME_LEN)) ||
                    (r_pos >= rec.len)) begin
                    n_alive[i] = 1'b0;
                end else if (fb != ch) begin
                    n_alive[i] = 1'b0;
                end else if ((r_pos + POS_W'(1)) == rec.len) begin
                    n_comp[i] = 1'b1;
                end
            end
        end
        // Position saturates; the last byte rearms for the next token.
        if (i_item.last_byte) begin
            n_pos = '0;
        end else if (in_range) begin
            n_pos = r_pos + POS_W'(1);
        end else begin
            n_pos = r_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_kind  <= '0;
            r_alive <= '1;
            r_comp  <= '0;
        end else if (i_step_en) begin
            r_pos   <= n_pos;
            r_kind  <= n_kind;
            r_alive <= n_alive;
            r_comp  <= n_comp;
        end
    end

    assign o_fin_vec  = n_comp;
    assign o_fin_kind = n_kind;

endmodule

>>> src/htm_result_stage.sv
// Holds the completed-entry vector of a token and encodes it into the result register.
module htm_result_stage
    import htm_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_fin_load,
    input  logic [MAX_ENTRIES-1:0] i_fin_vec,
    input  logic [KIND_W-1:0]      i_fin_kind,
    output logic                   o_fin_free,
    htm_chan_if.source             o_res_chan
);

    logic                   r_fin_valid, n_fin_valid;
    logic [MAX_ENTRIES-1:0] r_fin_vec;
    logic [KIND_W-1:0]      r_fin_kind;
    logic                   r_out_valid;
    t_out_item              r_out, n_out;
    logic                   out_free;

    assign out_free   = !r_out_valid || o_res_chan.ready;
    assign o_fin_free = !r_fin_valid || out_free;

    // Pick the first completed entry with a one-hot mask, then OR in its index and length.
    always_comb begin
        logic [MAX_ENTRIES-1:0] first;
        t_rom_rec               rec;
        first         = r_fin_vec & ~(r_fin_vec - MAX_ENTRIES'(1));
        n_out.found       = |r_fin_vec;
        n_out.entry_index = '0;
        n_out.name_length = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            rec = rom_entry(r_fin_kind, ENTRY_IDX_W'(i));
            if (first[i]) begin
                n_out.entry_index = n_out.entry_index | ENTRY_IDX_W'(i);
                n_out.name_length = n_out.name_length | rec.len;
            end
        end
    end

    always_comb begin
        if (i_fin_load) begin
            n_fin_valid = 1'b1;
        end else if (out_free) begin
            n_fin_valid = 1'b0;
        end else begin
            n_fin_valid = r_fin_valid;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_fin_valid <= n_fin_valid;
            if (out_free) begin
                r_out_valid <= r_fin_valid;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_fin_load) begin
            r_fin_vec  <= i_fin_vec;
            r_fin_kind <= i_fin_kind;
        end
        if (out_free && r_fin_valid) begin
            r_out <= n_out;
        end
    end

    assign o_res_chan.valid   = r_out_valid;
    assign o_res_chan.payload = r_out;

endmodule

>>> dv/testbench.sv
// Self-checking testbench of the HTTP token table matcher core.
`timescale 1ns / 100ps

module testbench;
    import htm_pkg::*;

    localparam int MAX_NAME_LEN = MAX_NAME_LEN_DEF;
    localparam int MAX_ENTRIES  = MAX_ENTRIES_DEF;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int TOKEN_BYTES  = 1000;
    localparam int DRAIN_CYCLES = 8;

    // One directed token: kind, text, and the result where it is obvious.
    typedef struct {
        t_table_kind kind;
        string       text;
        bit          high_bit;
        bit          typed;
        bit          found;
        int          index;
        int          length;
    } t_token_row;

    // Typed-in result of a token, used in place of the prediction when set.
    typedef struct packed {
        logic      typed;
        t_out_item res;
    } t_typed_match;

    logic i_clk = 1'b0;
    logic i_rst_n;

    htm_chan_if #(.t_payload(t_in_item))  in_chan ();
    htm_chan_if #(.t_payload(t_out_item)) res_chan ();

    http_token_table_matcher_core #(
        .MAX_NAME_LEN(MAX_NAME_LEN),
        .MAX_ENTRIES (MAX_ENTRIES)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_chan (in_chan),
        .o_res_chan(res_chan)
    );

    // Clock with a 12 ns period.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Name tables, in the order the block searches them.
    string req_names [21] = '{
        "User-Agent", "TE", "Referer", "Range", "Proxy-Authorization",
        "Max-Forwards", "If-Unmodified-Since", "If-Range", "If-None-Match",
        "If-Modified-Since", "If-Match", "Host", "From", "Expect",
        "Authorization", "Accept-Language", "Accept-Encoding", "Accept-Charset",
        "Accept", "X-API-Key", "Proxy-Connection"
    };
    string rsp_names [9] = '{
        "WWW-Authenticate", "Vary", "Server", "Retry-After", "Proxy-Authenticate",
        "Location", "ETag", "Age", "Accept-Ranges"
    };
    string gen_names [11] = '{
        "Warning", "Via", "Upgrade", "Transfer-Encoding",
        "Content-Transfer-Encoding", "Trailer", "Pragma", "Date", "Connection",
        "Keep-Alive", "Cache-Control"
    };
    string ent_names [10] = '{
        "Last-Modified", "Expires", "Content-Type", "Content-Range", "Content-MD5",
        "Content-Location", "Content-Length", "Content-Language",
        "Content-Encoding", "Allow"
    };
    string mth_names [8] = '{
        "OPTIONS", "GET", "HEAD", "POST", "PUT", "DELETE", "TRACE", "CONNECT"
    };
    bit    mth_supported [8] = '{0, 1, 0, 1, 0, 0, 0, 1};
    string ver_names [2] = '{"HTTP/1.0", "HTTP/1.1"};

    // Directed tokens; later bytes of each token carry a random kind.
    t_token_row directed_rows [12] = '{
        '{KIND_METHOD,   "get",                             0, 1, 1, 1,  3},
        '{KIND_METHOD,   "PoSt",                            0, 1, 1, 3,  4},
        '{KIND_METHOD,   "CONNECT",                         0, 0, 0, 0,  0},
        '{KIND_METHOD,   "HEAD",                            0, 1, 0, 0,  0},
        '{KIND_REQUEST,  "te",                              0, 1, 1, 1,  2},
        '{KIND_VERSION,  "HTTP/1.1",                        0, 1, 1, 1,  8},
        '{KIND_REQUEST,  "x",                               0, 1, 0, 0,  0},
        '{KIND_RESPONSE, "AGE",                             1, 1, 0, 0,  0},
        '{KIND_RESPONSE, "Date",                            0, 0, 0, 0,  0},
        '{KIND_REQUEST,  "Content-Transfer-Encoding-Extra", 0, 1, 1, 25, 25},
        '{KIND_REQUEST,  "allow",                           0, 1, 1, 41, 5},
        '{KIND_REQUEST,  "Accept-Language",                 0, 1, 1, 15, 15}
    };

    // Stimulus, typed results and expected results.
    t_in_item     token_bytes_q [$];
    t_typed_match typed_match_q [$];
    t_out_item    expected_match_q [$];
    int           total_bytes;
    int           accepted_bytes;
    int           result_count;
    int           mismatch_count;
    int           cycle_count;

    // Predictor state.
    bit          cand_alive    [MAX_ENTRIES];
    bit          cand_complete [MAX_ENTRIES];
    int          tok_pos;
    t_table_kind tok_kind;

    // Idle control of both sides.
    int send_gap_left;
    int send_calm;
    int res_stall_left;
    int res_calm;

    // Name of an entry of a kind, or an empty string past the table end.
    function automatic string entry_text(input t_table_kind k, input int idx);
        string txt;
        int    rest;
        txt  = "";
        rest = idx - ((k == KIND_REQUEST) ? 21 : 9);
        case (k)
            KIND_REQUEST:  if (idx < 21) txt = req_names[idx];
            KIND_RESPONSE: if (idx < 9) txt = rsp_names[idx];
            KIND_METHOD:   if (idx < 8) txt = mth_names[idx];
            KIND_VERSION:  if (idx < 2) txt = ver_names[idx];
            default: ;
        endcase
        if ((k == KIND_REQUEST || k == KIND_RESPONSE) && rest >= 0) begin
            if (rest < 11) begin
                txt = gen_names[rest];
            end else if (rest < 21) begin
                txt = ent_names[rest - 11];
            end
        end
        return txt;
    endfunction

    // Length of an entry that can match; zero for unsupported methods.
    function automatic int candidate_len(input t_table_kind k, input int idx);
        string txt;
        if (k == KIND_METHOD && (idx >= 8 || !mth_supported[idx])) begin
            return 0;
        end
        txt = entry_text(k, idx);
        return txt.len();
    endfunction

    function automatic int entry_count(input t_table_kind k);
        case (k)
            KIND_REQUEST:  return 42;
            KIND_RESPONSE: return 30;
            KIND_METHOD:   return 8;
            default:       return 2;
        endcase
    endfunction

    function automatic logic [7:0] lower_case(input logic [7:0] c);
        return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    // Advances the predictor by one byte; returns 1 when the byte closes a token.
    function automatic bit predict_match(input t_in_item item, output t_out_item res);
        int    idx;
        int    len;
        string nm;
        bit    done;
        res = '0;
        if (tok_pos == 0) begin
            tok_kind = t_table_kind'(item.table_kind);
            for (idx = 0; idx < MAX_ENTRIES; idx++) begin
                cand_alive[idx]    = 1'b1;
                cand_complete[idx] = 1'b0;
            end
        end
        // Compare the byte against every live entry; the position saturates.
        if (tok_pos < MAX_NAME_LEN) begin
            for (idx = 0; idx < MAX_ENTRIES; idx++) begin
                len = candidate_len(tok_kind, idx);
                if (cand_alive[idx] && !cand_complete[idx]) begin
                    if (len == 0 || len > MAX_NAME_LEN || tok_pos >= len) begin
                        cand_alive[idx] = 1'b0;
                    end else begin
                        nm = entry_text(tok_kind, idx);
                        if (lower_case(item.token_byte) != lower_case(nm[tok_pos])) begin
                            cand_alive[idx] = 1'b0;
                        end else if (tok_pos + 1 == len) begin
                            cand_complete[idx] = 1'b1;
                        end
                    end
                end
            end
            tok_pos++;
        end
        if (!item.last_byte) begin
            return 1'b0;
        end
        // The first complete entry in table order wins.
        tok_pos = 0;
        done    = 1'b0;
        for (idx = 0; idx < MAX_ENTRIES; idx++) begin
            if (cand_complete[idx] && !done) begin
                done            = 1'b1;
                res.found       = 1'b1;
                res.entry_index = ENTRY_IDX_W'(idx);
                res.name_length = NAME_LEN_W'(candidate_len(tok_kind, idx));
            end
        end
        return 1'b1;
    endfunction

    // Random idle length: mostly none or short, a few long, with calm stretches.
    function automatic int pick_gap(inout int calm_left);
        int roll;
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 4) begin
            calm_left = $urandom_range(20, 80);
            return 0;
        end
        if (roll < 55) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 10);
        return $urandom_range(11, 30);
    endfunction

    // Queues the bytes of one token; the kind is valid only on the first byte.
    task automatic add_token(input t_table_kind k, input logic [7:0] bytes [$],
                             input t_typed_match note);
        t_in_item item;
        int       j;
        for (j = 0; j < bytes.size(); j++) begin
            item.token_byte = bytes[j];
            item.last_byte  = (j == bytes.size() - 1);
            item.table_kind = (j == 0) ? k : KIND_W'($urandom_range(0, 3));
            token_bytes_q.push_back(item);
        end
        typed_match_q.push_back(note);
        total_bytes += bytes.size();
    endtask

    // Stimulus build, reset and end of run.
    initial begin
        logic [7:0]   bytes [$];
        t_typed_match note;
        t_table_kind  k;
        string        nm;
        logic [7:0]   c;
        int           r;
        int           j;
        int           cut;
        int           tail;

        in_chan.valid   = 1'b0;
        in_chan.payload = '0;
        res_chan.ready  = 1'b0;
        i_rst_n         = 1'b0;
        total_bytes     = 0;
        accepted_bytes  = 0;
        result_count    = 0;
        mismatch_count  = 0;
        send_gap_left   = 0;
        send_calm       = 0;
        res_stall_left  = 0;
        res_calm        = 0;
        tok_pos         = 0;
        tok_kind        = KIND_REQUEST;

        // Directed tokens from the table.
        foreach (directed_rows[r]) begin
            bytes.delete();
            for (j = 0; j < directed_rows[r].text.len(); j++) begin
                bytes.push_back(directed_rows[r].text[j] |
                                (directed_rows[r].high_bit ? 8'h80 : 8'h00));
            end
            note.typed           = directed_rows[r].typed;
            note.res.found       = directed_rows[r].found;
            note.res.entry_index = ENTRY_IDX_W'(directed_rows[r].index);
            note.res.name_length = NAME_LEN_W'(directed_rows[r].length);
            add_token(directed_rows[r].kind, bytes, note);
        end

        // Random tokens: mostly table names with random case, cuts and tails.
        note = '0;
        while (total_bytes < TOKEN_BYTES) begin
            bytes.delete();
            k = t_table_kind'($urandom_range(0, 3));
            if ($urandom_range(0, 3) != 0) begin
                nm  = entry_text(k, $urandom_range(0, entry_count(k) - 1));
                cut = nm.len();
                if ($urandom_range(0, 5) == 0) cut = $urandom_range(1, nm.len());
                for (j = 0; j < cut; j++) begin
                    c = nm[j];
                    if (((c >= "A" && c <= "Z") || (c >= "a" && c <= "z")) &&
                        $urandom_range(0, 1) == 1) begin
                        c = c ^ 8'h20;
                    end
                    bytes.push_back(c);
                end
                if ($urandom_range(0, 7) == 0) begin
                    bytes[$urandom_range(0, bytes.size() - 1)] = 8'($urandom_range(0, 255));
                end
                r = $urandom_range(0, 9);
                tail = (r < 4) ? 0 : (r < 8) ? $urandom_range(1, 4) : $urandom_range(5, 12);
            end else begin
                tail = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) :
                                                     $urandom_range(1, 6);
            end
            for (j = 0; j < tail; j++) begin
                bytes.push_back(8'($urandom_range(0, 255)));
            end
            add_token(k, bytes, note);
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (accepted_bytes < total_bytes || expected_match_q.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && expected_match_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Byte sender with random gaps between transfers.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_chan.valid <= 1'b0;
        end else if (!in_chan.valid || in_chan.ready) begin
            if (send_gap_left > 0) begin
                send_gap_left--;
                in_chan.valid <= 1'b0;
            end else if (token_bytes_q.size() > 0) begin
                in_chan.payload <= token_bytes_q.pop_front();
                in_chan.valid   <= 1'b1;
                send_gap_left = pick_gap(send_calm);
            end else begin
                in_chan.valid <= 1'b0;
            end
        end
    end

    // Result receiver with random stalls.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_chan.ready <= 1'b0;
        end else if (res_stall_left > 0) begin
            res_stall_left--;
            res_chan.ready <= 1'b0;
        end else begin
            res_chan.ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) res_stall_left = pick_gap(res_calm);
        end
    end

    // Prediction of accepted bytes and checking of accepted results.
    always @(posedge i_clk) begin
        t_out_item    predicted;
        t_out_item    wanted;
        t_typed_match note;
        if (i_rst_n && in_chan.valid && in_chan.ready) begin
            accepted_bytes++;
            if (predict_match(in_chan.payload, predicted)) begin
                note = typed_match_q.pop_front();
                expected_match_q.push_back(note.typed ? note.res : predicted);
            end
        end
        if (i_rst_n && res_chan.valid && res_chan.ready) begin
            result_count++;
            if (expected_match_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("result %0d: unexpected transfer found=%0d index=%0d length=%0d",
                             result_count, res_chan.payload.found,
                             res_chan.payload.entry_index, res_chan.payload.name_length);
                end
            end else begin
                wanted = expected_match_q.pop_front();
                if (res_chan.payload.found !== wanted.found ||
                    res_chan.payload.entry_index !== wanted.entry_index ||
                    res_chan.payload.name_length !== wanted.name_length) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("result %0d: expected found=%0d index=%0d length=%0d, %s%0d %s%0d %s%0d",
                                 result_count, wanted.found, wanted.entry_index,
                                 wanted.name_length, "got found=", res_chan.payload.found,
                                 "index=", res_chan.payload.entry_index,
                                 "length=", res_chan.payload.name_length);
                    end
                end
            end
        end
    end

    // Watchdog on the whole run.
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

endmodule

>>> filelist.f
src/htm_pkg.sv
src/htm_chan_if.sv
src/htm_match_stage.sv
src/htm_result_stage.sv
src/http_token_table_matcher_core.sv
dv/testbench.sv
